### rtl/kmst_pkg.sv
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types, sizes and helpers for the Kruskal spanning tree unit.
// ----------------------------------------------------------------------------
package kmst_pkg;

   localparam int NODES       = 64;
   localparam int MAX_EDGES   = 1024;
   localparam int WEIGHT_BITS = 16;

   localparam int NODE_W    = 6;
   localparam int WEIGHT_W  = 16;
   localparam int SUM_W     = 22;
   localparam int EDGE_W    = 2 * NODE_W + WEIGHT_W;
   localparam int ADDR_W    = $clog2((MAX_EDGES > 1) ? MAX_EDGES : 2);
   localparam int COUNT_W   = $clog2(MAX_EDGES + 1);
   localparam int W_USED    = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
   localparam int W_SHIFT   = WEIGHT_W - W_USED;

   localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(2097151);
   localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(2097152);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_SCAN,
      ST_CHECK,
      ST_EMIT,
      ST_SUMMARY
   } state_type;

   typedef struct packed {
      logic              init;
      logic              merge;
      logic [NODE_W-1:0] merge_from;
      logic [NODE_W-1:0] merge_to;
   } cell_ctrl_type;

   function automatic logic signed [WEIGHT_W-1:0] decode_weight(
      input logic [WEIGHT_W-1:0] raw
   );
      logic [WEIGHT_W-1:0] shifted;
      shifted = raw << W_SHIFT;
      return $signed(shifted) >>> W_SHIFT;
   endfunction

endpackage

### rtl/kruskal_minimum_spanning_tree_unit.sv
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_unit
// Loads weighted edges, then emits the minimum spanning tree edges in
// ascending weight order with a running sum, followed by a summary.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  req      in         req_valid/stall    edge_from, edge_to, edge_weight, last_edge
//  rsp      out        rsp_valid/stall    tree_*, weight_sum, is_summary, overflowed,
//                                         last_result
//
//  Loading takes one edge transaction per cycle while no run is in progress.
//  Each candidate edge costs one scan of the edge RAM.
//  An edge that joins two components adds one output transaction.
//  Component labels sit in a row of 64 node cells; all cells of a component relabel together.
//  Reset is synchronous; the row is set up at the start of every run.
//  While a run is in progress the input is stalled; results wait on rsp_stall.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kmst_pkg::NODE_W-1:0]          req_edge_from,
   input  logic [kmst_pkg::NODE_W-1:0]          req_edge_to,
   input  logic signed [kmst_pkg::WEIGHT_W-1:0] req_edge_weight,
   input  logic                                 req_last_edge,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [kmst_pkg::NODE_W-1:0]          rsp_tree_from,
   output logic [kmst_pkg::NODE_W-1:0]          rsp_tree_to,
   output logic signed [kmst_pkg::WEIGHT_W-1:0] rsp_tree_weight,
   output logic signed [kmst_pkg::SUM_W-1:0]    rsp_weight_sum,
   output logic                                 rsp_is_summary,
   output logic                                 rsp_overflowed,
   output logic                                 rsp_last_result
);
   import kmst_pkg::*;

   state_type state_ff, state_in;

   logic [COUNT_W-1:0]         count_ff;
   logic                       overflow_ff;
   logic [COUNT_W-1:0]         scan_idx_ff;
   logic                       data_valid_ff;
   logic [COUNT_W-1:0]         data_idx_ff;
   logic                       best_valid_ff;
   logic signed [WEIGHT_W-1:0] best_w_ff;
   logic [COUNT_W-1:0]         best_idx_ff;
   logic [NODE_W-1:0]          best_a_ff, best_b_ff;
   logic                       prev_valid_ff;
   logic signed [WEIGHT_W-1:0] prev_w_ff;
   logic [COUNT_W-1:0]         prev_idx_ff;
   logic signed [SUM_W-1:0]    total_ff;
   logic [NODE_W-1:0]          emitted_ff;

   logic                       req_take, rsp_take;
   logic                       node_ok, store_edge;
   logic                       scan_done;
   logic [EDGE_W-1:0]          rd_data;
   logic signed [WEIGHT_W-1:0] cand_w;
   logic                       after_prev, better;
   logic [NODE_W-1:0]          label_a, label_b;
   logic                       joins;
   logic signed [SUM_W:0]      sum_wide;
   logic signed [SUM_W-1:0]    sum_sat;
   cell_ctrl_type              cell_ctrl;

   logic [NODE_W-1:0] cell_la [NODES];
   logic [NODE_W-1:0] cell_lb [NODES];

   assign req_take   = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign node_ok    = ({1'b0, req_edge_from} < (NODE_W + 1)'(NODES)) &&
                       ({1'b0, req_edge_to} < (NODE_W + 1)'(NODES));
   assign store_edge = req_take && node_ok && (count_ff < COUNT_W'(MAX_EDGES));
   assign scan_done  = (scan_idx_ff == count_ff) && !data_valid_ff;

   kmst_ram #(
      .WIDTH (EDGE_W),
      .DEPTH (2 ** ADDR_W)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (store_edge),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data ({req_edge_from, req_edge_to, decode_weight(req_edge_weight)}),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   for (genvar g = 0; g < NODES; g++) begin : g_cell
      kmst_node_cell u_cell (
         .clock      (clock),
         .node_index (NODE_W'(g)),
         .ctrl       (cell_ctrl),
         .query_a    (best_a_ff),
         .query_b    (best_b_ff),
         .label_a    (cell_la[g]),
         .label_b    (cell_lb[g])
      );
   end

   always_comb begin
      label_a = '0;
      label_b = '0;
      for (int i = 0; i < NODES; i++) begin
         label_a = label_a | cell_la[i];
         label_b = label_b | cell_lb[i];
      end
   end

   assign joins    = (label_a != label_b);
   assign cand_w   = $signed(rd_data[WEIGHT_W-1:0]);
   assign after_prev = !prev_valid_ff || (cand_w > prev_w_ff) ||
                       ((cand_w == prev_w_ff) && (data_idx_ff > prev_idx_ff));
   assign better   = !best_valid_ff || (cand_w < best_w_ff);
   assign sum_wide = (SUM_W + 1)'(total_ff) + (SUM_W + 1)'(best_w_ff);

   always_comb begin
      if (sum_wide > SUM_MAX) begin
         sum_sat = SUM_MAX[SUM_W-1:0];
      end else if (sum_wide < SUM_MIN) begin
         sum_sat = SUM_MIN[SUM_W-1:0];
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take && req_last_edge) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = (count_ff == '0) ? ST_SUMMARY : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (!best_valid_ff) begin
               state_in = ST_SUMMARY;
            end else if (joins) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               state_in = (emitted_ff == NODE_W'(NODES - 2)) ? ST_SUMMARY : ST_SCAN;
            end
         end
         ST_SUMMARY: begin
            if (rsp_take) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      cell_ctrl  = '{init: 1'b0, merge: 1'b0, merge_from: label_b, merge_to: label_a};
      unique case (state_ff)
         ST_LOAD:    req_stall = 1'b0;
         ST_INIT:    cell_ctrl.init = 1'b1;
         ST_SCAN:    ;
         ST_CHECK:   cell_ctrl.merge = best_valid_ff && joins;
         ST_EMIT:    rsp_valid = 1'b1;
         ST_SUMMARY: rsp_valid = 1'b1;
         default:    ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         data_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         prev_valid_ff <= 1'b0;
         scan_idx_ff   <= '0;
         total_ff      <= '0;
         emitted_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         unique case (state_ff)
            ST_LOAD: begin
               if (store_edge) begin
                  count_ff <= count_ff + COUNT_W'(1);
               end else if (req_take && node_ok) begin
                  overflow_ff <= 1'b1;
               end
            end
            ST_INIT: begin
               total_ff      <= '0;
               emitted_ff    <= '0;
               prev_valid_ff <= 1'b0;
               best_valid_ff <= 1'b0;
               scan_idx_ff   <= '0;
            end
            ST_SCAN: begin
               data_valid_ff <= (scan_idx_ff != count_ff);
               if (scan_idx_ff != count_ff) begin
                  scan_idx_ff   <= scan_idx_ff + COUNT_W'(1);
                  data_idx_ff   <= scan_idx_ff;
               end
               if (data_valid_ff && after_prev && better) begin
                  best_valid_ff <= 1'b1;
                  best_w_ff     <= cand_w;
                  best_idx_ff   <= data_idx_ff;
                  best_a_ff     <= rd_data[EDGE_W-1 -: NODE_W];
                  best_b_ff     <= rd_data[WEIGHT_W +: NODE_W];
               end
            end
            ST_CHECK: begin
               prev_valid_ff <= 1'b1;
               prev_w_ff     <= best_w_ff;
               prev_idx_ff   <= best_idx_ff;
               scan_idx_ff   <= '0;
               if (best_valid_ff && joins) begin
                  total_ff <= sum_sat;
               end else begin
                  best_valid_ff <= 1'b0;
               end
            end
            ST_EMIT: begin
               if (rsp_take) begin
                  emitted_ff    <= emitted_ff + NODE_W'(1);
                  best_valid_ff <= 1'b0;
               end
            end
            ST_SUMMARY: begin
               if (rsp_take) begin
                  count_ff    <= '0;
                  overflow_ff <= 1'b0;
                  total_ff    <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_is_summary  = (state_ff == ST_SUMMARY);
   assign rsp_last_result = rsp_is_summary;
   assign rsp_tree_from   = rsp_is_summary ? '0 : best_a_ff;
   assign rsp_tree_to     = rsp_is_summary ? '0 : best_b_ff;
   assign rsp_tree_weight = rsp_is_summary ? '0 : best_w_ff;
   assign rsp_weight_sum  = total_ff;
   assign rsp_overflowed  = overflow_ff;

endmodule

### rtl/kmst_ram.sv
// ----------------------------------------------------------------------------
// kmst_ram
// Generic single write port RAM with a registered read port.
// ----------------------------------------------------------------------------
module kmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/kmst_node_cell.sv
// ----------------------------------------------------------------------------
// kmst_node_cell
// One node of the component row: holds the node's component label.
// ----------------------------------------------------------------------------
module kmst_node_cell (
   input  logic                            clock,
   input  logic [kmst_pkg::NODE_W-1:0]     node_index,
   input  kmst_pkg::cell_ctrl_type         ctrl,
   input  logic [kmst_pkg::NODE_W-1:0]     query_a,
   input  logic [kmst_pkg::NODE_W-1:0]     query_b,
   output logic [kmst_pkg::NODE_W-1:0]     label_a,
   output logic [kmst_pkg::NODE_W-1:0]     label_b
);
   import kmst_pkg::*;

   logic [NODE_W-1:0] label_ff;
   logic [NODE_W-1:0] label_in;

   always_comb begin
      label_in = label_ff;
      if (ctrl.init) begin
         label_in = node_index;
      end else if (ctrl.merge && (label_ff == ctrl.merge_from)) begin
         label_in = ctrl.merge_to;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
   end

   assign label_a = (query_a == node_index) ? label_ff : '0;
   assign label_b = (query_b == node_index) ? label_ff : '0;

endmodule

### tb/kruskal_minimum_spanning_tree_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kruskal_minimum_spanning_tree_unit_test
// Self-checking testbench for the Kruskal spanning tree unit. A table of
// directed edge sets, a store-full run and random edge sets are loaded
// through the request channel, with random idling after the table. A
// predictor sorts each set stably by weight and runs union-find over it.
// Every tree edge and summary transaction is checked field by field.
// ----------------------------------------------------------------------------
module kruskal_minimum_spanning_tree_unit_test;
   import kmst_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000000;
   localparam int RANDOM_ITEMS   = 420;

   typedef struct {
      logic [NODE_W-1:0]          tree_from;
      logic [NODE_W-1:0]          tree_to;
      logic signed [WEIGHT_W-1:0] tree_weight;
      logic signed [SUM_W-1:0]    weight_sum;
      logic                       is_summary;
      logic                       overflowed;
      logic                       last_result;
   } tree_item_type;

   typedef struct {
      logic [NODE_W-1:0]          from_node;
      logic [NODE_W-1:0]          to_node;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last_edge;
      logic                       literal;
      logic                       literal_joins;
   } edge_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [NODE_W-1:0]          req_edge_from = '0;
   logic [NODE_W-1:0]          req_edge_to = '0;
   logic signed [WEIGHT_W-1:0] req_edge_weight = '0;
   logic                       req_last_edge = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [NODE_W-1:0]          rsp_tree_from;
   logic [NODE_W-1:0]          rsp_tree_to;
   logic signed [WEIGHT_W-1:0] rsp_tree_weight;
   logic signed [SUM_W-1:0]    rsp_weight_sum;
   logic                       rsp_is_summary;
   logic                       rsp_overflowed;
   logic                       rsp_last_result;

   tree_item_type              expected_tree_items[$];
   logic [NODE_W-1:0]          stored_from[MAX_EDGES];
   logic [NODE_W-1:0]          stored_to[MAX_EDGES];
   logic signed [WEIGHT_W-1:0] stored_weight[MAX_EDGES];
   int                         stored_count = 0;
   logic                       store_overflow = 1'b0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int results_seen = 0;
   int edges_sent = 0;
   int runs_sent = 0;
   int idle_cycles = 0;

   edge_row_type directed_rows[] = '{
      '{6'd5,  6'd5,  16'sd100,     1'b1, 1'b1, 1'b0},
      '{6'd0,  6'd63, 16'sd32767,   1'b1, 1'b1, 1'b1},
      '{6'd63, 6'd0,  -16'sd32768,  1'b1, 1'b1, 1'b1},
      '{6'd42, 6'd21, 16'sd0,       1'b1, 1'b1, 1'b1},
      '{6'd1,  6'd2,  16'sd10,      1'b0, 1'b0, 1'b0},
      '{6'd2,  6'd3,  16'sd10,      1'b0, 1'b0, 1'b0},
      '{6'd1,  6'd3,  16'sd5,       1'b0, 1'b0, 1'b0},
      '{6'd3,  6'd1,  16'sd10,      1'b0, 1'b0, 1'b0},
      '{6'd4,  6'd5,  -16'sd7,      1'b0, 1'b0, 1'b0},
      '{6'd5,  6'd4,  -16'sd7,      1'b0, 1'b0, 1'b0},
      '{6'd7,  6'd7,  -16'sd32768,  1'b0, 1'b0, 1'b0},
      '{6'd1,  6'd4,  16'sd0,       1'b1, 1'b0, 1'b0}
   };

   kruskal_minimum_spanning_tree_unit uut (.*);

   always #10 clock = ~clock;

   function automatic logic [NODE_W-1:0] find_root(ref logic [NODE_W-1:0] parent[NODES],
                                                   input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] root;
      logic [NODE_W-1:0] next_node;
      root = node;
      while (parent[root] != root) root = parent[root];
      while (parent[node] != root) begin
         next_node = parent[node];
         parent[node] = root;
         node = next_node;
      end
      return root;
   endfunction

   function automatic void build_spanning_tree(ref tree_item_type items[$]);
      int                order[MAX_EDGES];
      logic [NODE_W-1:0] parent[NODES];
      int                rank[NODES];
      int                j;
      int                cur;
      int                joins;
      int                total;
      logic [NODE_W-1:0] ra;
      logic [NODE_W-1:0] rb;
      tree_item_type     item;
      for (int i = 0; i < stored_count; i++) begin
         cur = i;
         j = i;
         while (j > 0 && stored_weight[order[j - 1]] > stored_weight[cur]) begin
            order[j] = order[j - 1];
            j--;
         end
         order[j] = cur;
      end
      for (int n = 0; n < NODES; n++) begin
         parent[n] = NODE_W'(n);
         rank[n] = 0;
      end
      joins = 0;
      total = 0;
      for (int i = 0; i < stored_count && joins < NODES - 1; i++) begin
         cur = order[i];
         ra = find_root(parent, stored_from[cur]);
         rb = find_root(parent, stored_to[cur]);
         if (ra != rb) begin
            if (rank[ra] > rank[rb]) begin
               parent[rb] = ra;
            end else if (rank[ra] < rank[rb]) begin
               parent[ra] = rb;
            end else begin
               parent[ra] = rb;
               if (rank[rb] < 7) rank[rb]++;
            end
            total += stored_weight[cur];
            if (total > 2097151) total = 2097151;
            if (total < -2097152) total = -2097152;
            item = '{stored_from[cur], stored_to[cur], stored_weight[cur],
                     SUM_W'(total), 1'b0, store_overflow, 1'b0};
            items = {items, item};
            joins++;
         end
      end
      item = '{'0, '0, '0, SUM_W'(total), 1'b1, store_overflow, 1'b1};
      items = {items, item};
      stored_count = 0;
      store_overflow = 1'b0;
   endfunction

   task automatic send_edge(input edge_row_type row);
      int            gap;
      tree_item_type run_items[$];
      tree_item_type item;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 12) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_edge_from   <= row.from_node;
      req_edge_to     <= row.to_node;
      req_edge_weight <= row.weight;
      req_last_edge   <= row.last_edge;
      do @(posedge clock); while (req_stall);
      edges_sent++;
      if (stored_count < MAX_EDGES) begin
         stored_from[stored_count]   = row.from_node;
         stored_to[stored_count]     = row.to_node;
         stored_weight[stored_count] = row.weight;
         stored_count++;
      end else begin
         store_overflow = 1'b1;
      end
      if (row.last_edge) begin
         runs_sent++;
         build_spanning_tree(run_items);
         if (row.literal) begin
            if (row.literal_joins) begin
               item = '{row.from_node, row.to_node, row.weight, SUM_W'(row.weight),
                        1'b0, 1'b0, 1'b0};
               expected_tree_items = {expected_tree_items, item};
            end
            item = '{'0, '0, '0, row.literal_joins ? SUM_W'(row.weight) : '0,
                     1'b1, 1'b0, 1'b1};
            expected_tree_items = {expected_tree_items, item};
         end else begin
            expected_tree_items = {expected_tree_items, run_items};
         end
      end
   endtask

   task automatic send_random_set(input int edge_total, input int span);
      edge_row_type row;
      int           pick;
      for (int i = 0; i < edge_total; i++) begin
         row.from_node = NODE_W'($urandom_range(span - 1));
         row.to_node   = NODE_W'($urandom_range(span - 1));
         pick = $urandom_range(9);
         if (pick == 0)      row.weight = 16'sh7FFF;
         else if (pick == 1) row.weight = 16'sh8000;
         else if (pick < 5)  row.weight = WEIGHT_W'($signed($urandom_range(8)) - 4);
         else                row.weight = WEIGHT_W'($urandom);
         row.last_edge = (i == edge_total - 1);
         row.literal = 1'b0;
         row.literal_joins = 1'b0;
         send_edge(row);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      tree_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_tree_items.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction: from %0d to %0d sum %0d",
                        rsp_tree_from, rsp_tree_to, rsp_weight_sum);
         end else begin
            want = expected_tree_items.pop_front();
            if (rsp_tree_from !== want.tree_from || rsp_tree_to !== want.tree_to ||
                rsp_tree_weight !== want.tree_weight ||
                rsp_weight_sum !== want.weight_sum ||
                rsp_is_summary !== want.is_summary ||
                rsp_overflowed !== want.overflowed ||
                rsp_last_result !== want.last_result) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: want %0d %0d %0d %0d %b%b%b got %0d %0d %0d %0d %b%b%b",
                           want.tree_from, want.tree_to, want.tree_weight,
                           want.weight_sum, want.is_summary, want.overflowed,
                           want.last_result, rsp_tree_from, rsp_tree_to,
                           rsp_tree_weight, rsp_weight_sum, rsp_is_summary,
                           rsp_overflowed, rsp_last_result);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      edge_row_type row;
      int           phase;
      int           random_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[r]) send_edge(directed_rows[r]);
      send_idle_pct = 11;
      stall_pct = 11;
      for (int i = 0; i < MAX_EDGES + 6; i++) begin
         row = '{NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)),
                 WEIGHT_W'($urandom), i == MAX_EDGES + 5, 1'b0, 1'b0};
         send_edge(row);
      end
      random_start = edges_sent;
      while (edges_sent - random_start < RANDOM_ITEMS) begin
         phase = ((edges_sent - random_start) * 4) / RANDOM_ITEMS;
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 74 : 11) : 0;
         stall_pct     = (phase == 2 || phase == 3) ? ((phase == 2) ? 74 : 11) : 0;
         case ($urandom_range(5))
            0:       send_random_set($urandom_range(60, 100), 64);
            1:       send_random_set($urandom_range(1, 12), 4);
            2:       send_random_set($urandom_range(1, 20), 16);
            default: send_random_set($urandom_range(1, 30), 64);
         endcase
      end
      req_valid <= 1'b0;
      while (expected_tree_items.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Loaded %0d edges in %0d runs, including one run past store capacity.",
               edges_sent, runs_sent);
      $display("Checked %0d result transactions under four idling phases.", results_seen);
      if (mismatch_count == 0 && expected_tree_items.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
